// File: hw/rtl/hgr_color_magnify_2x_assert.svh
// Assertion macros shared by the checker of the hi-res color magnifier.
`ifndef HGR_COLOR_MAGNIFY_2X_ASSERT_SVH
`define HGR_COLOR_MAGNIFY_2X_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define HGR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define HGR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/hgr_pkg.sv
// Shared types and constants of the hi-res color magnifier.
`timescale 1ns / 1ps
package hgr_pkg;

  // Defaults for the top level parameters
  localparam int MaxWidthBytesDflt = 40;
  localparam int MaxRowsDflt       = 192;

  // Decoupling queue between front and back
  localparam int QueueDepth = 2;

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH_BYTES = 2'd0,
    CFG_HEIGHT_ROWS = 2'd1
  } cfg_reg_e;

  // Cell colors; codes 6 and 7 draw as black
  typedef enum logic [2:0] {
    COLOR_BLACK  = 3'd0,
    COLOR_VIOLET = 3'd1,
    COLOR_GREEN  = 3'd2,
    COLOR_BLUE   = 3'd3,
    COLOR_ORANGE = 3'd4,
    COLOR_WHITE  = 3'd5
  } color_e;

  // Columns per packed byte
  localparam logic [2:0] ColsPerByte = 3'd7;

  // One completed byte, to be written on both doubled rows
  typedef struct packed {
    logic [7:0] src_row;
    logic [6:0] byte_col;
    logic [7:0] value;
    logic       done;
  } byte_wr_t;

endpackage

// File: hw/rtl/hgr_color_magnify_2x.sv
// Top level of the two-times hi-res color magnifier.
//
// Usage: color cells of a sprite enter in raster order on push_i/color_i and
// are accepted when push_i is high and full_o is low. Each cell becomes two
// destination columns, packed seven to a byte. Every completed byte leaves
// as two beats on the result side (rows 2r and 2r+1), offered while empty_o
// is low and taken when pop_i is high. last_of_run_o marks the second beat,
// image_done_o the second beat of the image's final byte.
// Width and height registers are written on cfg_valid_i/cfg_ready_o (ready is
// always high); the user must write them only while the block is idle, which the
// block itself does not enforce. A completed byte passes through the queue and the
// output register to the ports; its second beat follows once the first is popped.
// Throughput: one cell per cycle while full_o is low; the back end sends each
// completed byte as two beats and a byte completes at most every three cells, so a
// non-stalling receiver never throttles the input. A two-entry queue between the
// packing front end and the row-doubling back end absorbs receiver stalls; full_o
// rises only once the queue and the output register are both occupied.
// Reset clears all position state and sets both registers to one.
`timescale 1ns / 1ps
module hgr_color_magnify_2x #(
  parameter int MAX_WIDTH_BYTES = hgr_pkg::MaxWidthBytesDflt,
  parameter int MAX_ROWS        = hgr_pkg::MaxRowsDflt
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hgr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hgr_pkg::CfgDataW-1:0] cfg_data_i,
  // cell input
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [2:0]                   color_i,
  // byte writes
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [8:0]                   dest_row_o,
  output logic [6:0]                   dest_byte_col_o,
  output logic [7:0]                   value_o,
  output logic                         last_of_run_o,
  output logic                         image_done_o
);

  logic              accept;
  logic              wr_push;
  hgr_pkg::byte_wr_t wr_data;
  logic              q_full, q_empty, q_pop;
  hgr_pkg::byte_wr_t q_data;

  assign cfg_ready_o = 1'b1;
  assign full_o      = q_full;
  assign accept      = push_i && !q_full;

  hgr_front #(
    .MAX_WIDTH_BYTES(MAX_WIDTH_BYTES),
    .MAX_ROWS       (MAX_ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .color_i    (color_i),
    .wr_push_o  (wr_push),
    .wr_data_o  (wr_data)
  );

  hgr_queue #(
    .DEPTH(hgr_pkg::QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (wr_push),
    .wdata_i(wr_data),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .rdata_o(q_data)
  );

  hgr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (q_data),
    .q_pop_o        (q_pop),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .dest_row_o     (dest_row_o),
    .dest_byte_col_o(dest_byte_col_o),
    .value_o        (value_o),
    .last_of_run_o  (last_of_run_o),
    .image_done_o   (image_done_o)
  );

endmodule

// File: hw/rtl/hgr_front.sv
// Front end: config registers, column packing and raster position tracking.
`timescale 1ns / 1ps
module hgr_front #(
  parameter int MAX_WIDTH_BYTES = hgr_pkg::MaxWidthBytesDflt,
  parameter int MAX_ROWS        = hgr_pkg::MaxRowsDflt
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config writes
  input  logic                         cfg_we_i,
  input  logic [hgr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hgr_pkg::CfgDataW-1:0] cfg_data_i,
  // pixel input
  input  logic                         accept_i,
  input  logic [2:0]                   color_i,
  // completed bytes toward the queue
  output logic                         wr_push_o,
  output hgr_pkg::byte_wr_t            wr_data_o
);

  logic [5:0] width_q, width_d;
  logic [7:0] height_q, height_d;
  logic [6:0] bits_q, bits_d;
  logic       pal_q, pal_d;
  logic [2:0] phase_q, phase_d;
  logic [6:0] obi_q, obi_d;
  logic [8:0] pixel_q, pixel_d;
  logic [7:0] row_q, row_d;

  logic [5:0] eff_w;
  logic [7:0] eff_h;
  logic [8:0] wpx;
  logic       lit_l, lit_r, pal_c;
  logic       emit;
  logic [7:0] emit_val;
  logic       done;

  // Config register writes
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        hgr_pkg::CFG_WIDTH_BYTES: width_d  = cfg_data_i[5:0];
        hgr_pkg::CFG_HEIGHT_ROWS: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective image size: zero reads as one, large values saturate
  always_comb begin
    eff_w = width_q;
    if (width_q == 6'd0) begin
      eff_w = 6'd1;
    end else if ({1'b0, width_q} > 7'(MAX_WIDTH_BYTES)) begin
      eff_w = 6'(MAX_WIDTH_BYTES);
    end
    eff_h = height_q;
    if (height_q == 8'd0) begin
      eff_h = 8'd1;
    end else if ({1'b0, height_q} > 9'(MAX_ROWS)) begin
      eff_h = 8'(MAX_ROWS);
    end
  end

  // pixels per row = width * 7
  assign wpx = {eff_w, 3'b000} - {3'b000, eff_w};

  // Color classification
  assign lit_l = color_i inside {hgr_pkg::COLOR_VIOLET, hgr_pkg::COLOR_BLUE,
                                 hgr_pkg::COLOR_WHITE};
  assign lit_r = color_i inside {hgr_pkg::COLOR_GREEN, hgr_pkg::COLOR_ORANGE,
                                 hgr_pkg::COLOR_WHITE};
  assign pal_c = color_i inside {hgr_pkg::COLOR_BLUE, hgr_pkg::COLOR_ORANGE};

  // Packing of the two columns plus row and image bookkeeping
  always_comb begin
    logic [7:0] row_inc;
    logic [1:0] lit;
    row_inc  = row_q + 8'd1;
    lit      = {lit_r, lit_l};
    bits_d   = bits_q;
    pal_d    = pal_q;
    phase_d  = phase_q;
    obi_d    = obi_q;
    pixel_d  = pixel_q;
    row_d    = row_q;
    emit     = 1'b0;
    emit_val = '0;
    done     = 1'b0;
    if (accept_i) begin
      for (int k = 0; k < 2; k++) begin
        if (lit[k]) begin
          bits_d = bits_d | 7'(8'd1 << phase_d);
          if (pal_c) begin
            pal_d = 1'b1;
          end
        end
        phase_d = phase_d + 3'd1;
        if (phase_d == hgr_pkg::ColsPerByte) begin
          emit     = 1'b1;
          emit_val = {pal_d, bits_d};
          bits_d   = '0;
          pal_d    = 1'b0;
          phase_d  = '0;
        end
      end
      obi_d   = obi_q + 7'(emit);
      pixel_d = pixel_q + 9'd1;
      // end of a source row
      if (pixel_d >= wpx) begin
        pixel_d = '0;
        obi_d   = '0;
        bits_d  = '0;
        pal_d   = 1'b0;
        phase_d = '0;
        row_d   = row_inc;
        if ({1'b0, row_inc} >= {1'b0, eff_h}) begin
          row_d = '0;
          done  = 1'b1;
        end
      end
    end
  end

  assign wr_push_o          = emit;
  assign wr_data_o.src_row  = row_q;
  assign wr_data_o.byte_col = obi_q;
  assign wr_data_o.value    = emit_val;
  assign wr_data_o.done     = done;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 6'd1;
      height_q <= 8'd1;
      bits_q   <= '0;
      pal_q    <= 1'b0;
      phase_q  <= '0;
      obi_q    <= '0;
      pixel_q  <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      bits_q   <= bits_d;
      pal_q    <= pal_d;
      phase_q  <= phase_d;
      obi_q    <= obi_d;
      pixel_q  <= pixel_d;
      row_q    <= row_d;
    end
  end

endmodule

// File: hw/rtl/hgr_queue.sv
// Short queue of completed bytes between the front and back ends.
`timescale 1ns / 1ps
module hgr_queue #(
  parameter int DEPTH = hgr_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hgr_pkg::byte_wr_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output hgr_pkg::byte_wr_t rdata_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  hgr_pkg::byte_wr_t  mem_q [DEPTH];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: hw/rtl/hgr_back.sv
// Back end: writes each queued byte on both doubled rows, one beat per row.
`timescale 1ns / 1ps
module hgr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  // queue side
  input  logic              q_empty_i,
  input  hgr_pkg::byte_wr_t q_data_i,
  output logic              q_pop_o,
  // result side
  output logic              empty_o,
  input  logic              pop_i,
  output logic [8:0]        dest_row_o,
  output logic [6:0]        dest_byte_col_o,
  output logic [7:0]        value_o,
  output logic              last_of_run_o,
  output logic              image_done_o
);

  logic              valid_q, valid_d;
  logic              ky_q, ky_d;
  hgr_pkg::byte_wr_t ent_q;
  logic              beat_done;
  logic              free;

  // Output register is free when empty or when its second beat leaves
  assign beat_done = valid_q && pop_i;
  assign free      = !valid_q || (beat_done && ky_q);
  assign q_pop_o   = free && !q_empty_i;

  always_comb begin
    valid_d = valid_q;
    ky_d    = ky_q;
    if (free) begin
      valid_d = !q_empty_i;
      ky_d    = 1'b0;
    end else if (beat_done) begin
      ky_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ky_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      ky_q    <= ky_d;
    end
  end

  // Payload capture
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ent_q <= q_data_i;
    end
  end

  // Row is 2*src_row plus the beat number
  assign empty_o         = !valid_q;
  assign dest_row_o      = {ent_q.src_row, ky_q};
  assign dest_byte_col_o = ent_q.byte_col;
  assign value_o         = ent_q.value;
  assign last_of_run_o   = ky_q;
  assign image_done_o    = ky_q && ent_q.done;

endmodule

// File: hw/rtl/hgr_checker.sv
// Port-level checks of the magnifier's result side, bound to the top level.
`timescale 1ns / 1ps
`include "hgr_color_magnify_2x_assert.svh"
module hgr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty_o,
  input logic       pop_i,
  input logic [8:0] dest_row_o,
  input logic [6:0] dest_byte_col_o,
  input logic [7:0] value_o,
  input logic       last_of_run_o,
  input logic       image_done_o
);

  // image end is only flagged on the closing beat of a byte
  `HGR_ASSERT_IMP(a_done_on_last, !empty_o && image_done_o, last_of_run_o, "image_done without last_of_run")

  // first beat goes to the even row, second to the odd row
  `HGR_ASSERT_IMP(a_row_parity, !empty_o, dest_row_o[0] == last_of_run_o, "dest_row parity does not match beat")

  // a popped first beat is followed at once by its second beat, same byte
  `HGR_ASSERT_NXT(a_pair_follows, !empty_o && pop_i && !last_of_run_o, !empty_o && last_of_run_o && $stable(value_o) && $stable(dest_byte_col_o), "second beat of byte missing")

  // a waiting beat holds until taken
  `HGR_ASSERT_NXT(a_hold, !empty_o && !pop_i, !empty_o && $stable(value_o) && $stable(dest_row_o), "waiting beat changed")

endmodule

bind hgr_color_magnify_2x hgr_checker u_checker (.*);

// File: verif/hgr_color_magnify_2x_tb.sv
// Self-checking testbench for the two-times hi-res color magnifier.
`timescale 1ns / 1ps
module hgr_color_magnify_2x_tb;

  localparam int unsigned CellTarget  = 700;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned DrainSettle = 8;
  localparam int unsigned MaxPrinted  = 40;

  // Index with no register behind it; writes to it must be ignored
  localparam logic [hgr_pkg::CfgIdxW-1:0] CfgIdxSpare = 2'd3;
  // Codes outside the palette, drawn as black
  localparam logic [2:0] ColorSpare6 = 3'd6;
  localparam logic [2:0] ColorSpare7 = 3'd7;

  // One byte write as seen on the result ports
  typedef struct packed {
    logic [8:0] row;
    logic [6:0] col;
    logic [7:0] value;
    logic       last;
    logic       done;
  } byte_write_t;

  // Packing predictor plus the queue of byte writes still owed by the block
  class byte_write_predictor;
    logic [5:0]  width_reg  = 6'd1;
    logic [7:0]  height_reg = 8'd1;
    logic [6:0]  lit_cols   = '0;
    logic        palette    = 1'b0;
    logic [2:0]  col_phase  = '0;
    logic [6:0]  byte_idx   = '0;
    logic [8:0]  pixel_idx  = '0;
    logic [7:0]  src_row    = '0;
    byte_write_t owed_writes[$];
    int unsigned mismatches = 0;
    int unsigned writes_checked = 0;
    int unsigned images_closed = 0;

    function void write_reg(logic [hgr_pkg::CfgIdxW-1:0] idx,
                            logic [hgr_pkg::CfgDataW-1:0] data);
      if (idx == hgr_pkg::CFG_WIDTH_BYTES) width_reg = data[5:0];
      else if (idx == hgr_pkg::CFG_HEIGHT_ROWS) height_reg = data;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > hgr_pkg::MaxWidthBytesDflt) return hgr_pkg::MaxWidthBytesDflt;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > hgr_pkg::MaxRowsDflt) return hgr_pkg::MaxRowsDflt;
      return height_reg;
    endfunction

    function bit at_image_start();
      return pixel_idx == 0 && src_row == 0 && col_phase == 0;
    endfunction

    function int unsigned image_cells();
      return eff_width() * 7 * eff_height();
    endfunction

    function int unsigned pending();
      return owed_writes.size();
    endfunction

    function void clear_byte();
      lit_cols  = '0;
      palette   = 1'b0;
      col_phase = '0;
    endfunction

    // Advance the packing state by one cell; a finished byte owes two writes
    function void take_cell(logic [2:0] code);
      hgr_pkg::color_e c;
      logic            lit_left, lit_right, pal, have_byte, image_end;
      logic [7:0]      byte_val;
      logic [8:0]      row_base;
      logic [6:0]      byte_col;
      byte_write_t     w;
      c         = hgr_pkg::color_e'(code);
      lit_left  = c inside {hgr_pkg::COLOR_VIOLET, hgr_pkg::COLOR_BLUE,
                            hgr_pkg::COLOR_WHITE};
      lit_right = c inside {hgr_pkg::COLOR_GREEN, hgr_pkg::COLOR_ORANGE,
                            hgr_pkg::COLOR_WHITE};
      pal       = c inside {hgr_pkg::COLOR_BLUE, hgr_pkg::COLOR_ORANGE};
      have_byte = 1'b0;
      image_end = 1'b0;
      byte_val  = '0;
      row_base  = '0;
      byte_col  = '0;
      for (int k = 0; k < 2; k++) begin
        if (k == 0 ? lit_left : lit_right) begin
          lit_cols[col_phase] = 1'b1;
          if (pal) palette = 1'b1;
        end
        col_phase++;
        if (col_phase >= hgr_pkg::ColsPerByte) begin
          have_byte = 1'b1;
          byte_val  = {palette, lit_cols};
          row_base  = {src_row, 1'b0};
          byte_col  = byte_idx;
          byte_idx++;
          clear_byte();
        end
      end
      // row and image wrap, also when a shrunken size was already passed
      pixel_idx++;
      if (pixel_idx >= eff_width() * 7) begin
        pixel_idx = '0;
        byte_idx  = '0;
        clear_byte();
        src_row++;
        if (src_row >= eff_height()) begin
          src_row   = '0;
          image_end = 1'b1;
        end
      end
      if (have_byte) begin
        w = '{row: row_base, col: byte_col, value: byte_val, last: 1'b0, done: 1'b0};
        owed_writes.push_back(w);
        w.row  = row_base | 9'd1;
        w.last = 1'b1;
        w.done = image_end;
        owed_writes.push_back(w);
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= MaxPrinted) $display("ERROR @%0t: %s", $time, what);
    endtask

    task check_write(byte_write_t got);
      byte_write_t want;
      if (owed_writes.size() == 0) begin
        report($sformatf("unexpected write row %0d col %0d value 0x%02h",
                         got.row, got.col, got.value));
        return;
      end
      want = owed_writes.pop_front();
      writes_checked++;
      if (want.done && got.done === 1'b1) images_closed++;
      if (got.row !== want.row)
        report($sformatf("dest_row %0d, want %0d", got.row, want.row));
      if (got.col !== want.col)
        report($sformatf("dest_byte_col %0d, want %0d (row %0d)", got.col, want.col, want.row));
      if (got.value !== want.value)
        report($sformatf("value 0x%02h, want 0x%02h (row %0d col %0d)",
                         got.value, want.value, want.row, want.col));
      if (got.last !== want.last)
        report($sformatf("last_of_run %b, want %b (row %0d col %0d)",
                         got.last, want.last, want.row, want.col));
      if (got.done !== want.done)
        report($sformatf("image_done %b, want %b (row %0d col %0d)",
                         got.done, want.done, want.row, want.col));
    endtask
  endclass

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [hgr_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [hgr_pkg::CfgDataW-1:0] cfg_data_i  = '0;
  logic                         push_i      = 1'b0;
  logic                         full_o;
  logic [2:0]                   color_i     = '0;
  logic                         empty_o;
  logic                         pop_i       = 1'b0;
  logic [8:0]                   dest_row_o;
  logic [6:0]                   dest_byte_col_o;
  logic [7:0]                   value_o;
  logic                         last_of_run_o;
  logic                         image_done_o;

  byte_write_predictor predictor;
  bit          steady       = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned cells_sent   = 0;
  int unsigned reg_writes   = 0;
  int unsigned full_stalls  = 0;
  int unsigned quiet_cycles = 0;

  hgr_color_magnify_2x i_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .push_i,
    .full_o,
    .color_i,
    .empty_o,
    .pop_i,
    .dest_row_o,
    .dest_byte_col_o,
    .value_o,
    .last_of_run_o,
    .image_done_o
  );

  // Clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Result side: random pops, one long hold-off on request
  initial begin
    predictor = new;
    wait (rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        pop_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        pop_i <= steady || ($urandom_range(99) >= 37);
      end
      @(posedge clk_i);
      if (pop_i && !empty_o)
        predictor.check_write('{row: dest_row_o, col: dest_byte_col_o, value: value_o,
                                last: last_of_run_o, done: image_done_o});
    end
  end

  // Watchdog: ends the run when no beat moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push_i && !full_o) || (pop_i && !empty_o) || (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (push_i && full_o) full_stalls <= full_stalls + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("ERROR: no beat accepted for %0d cycles", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // One cell beat, with random idle cycles in front unless running steady
  task automatic offer_cell(input logic [2:0] code);
    while (!steady && $urandom_range(99) < 37) begin
      push_i  <= 1'b0;
      color_i <= 3'($urandom_range(7));
      @(posedge clk_i);
    end
    push_i  <= 1'b1;
    color_i <= code;
    do @(posedge clk_i); while (full_o);
    predictor.take_cell(code);
    cells_sent++;
  endtask

  // Register write beat; valid is lowered by the caller
  task automatic write_reg(input logic [hgr_pkg::CfgIdxW-1:0] idx,
                           input logic [hgr_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    predictor.write_reg(idx, data);
    reg_writes++;
  endtask

  task automatic configure(input logic [7:0] width_data, input logic [7:0] height_data,
                           input bit with_spare);
    if (with_spare) write_reg(CfgIdxSpare, 8'($urandom_range(255)));
    if ($urandom_range(1)) begin
      write_reg(hgr_pkg::CFG_WIDTH_BYTES, width_data);
      write_reg(hgr_pkg::CFG_HEIGHT_ROWS, height_data);
    end else begin
      write_reg(hgr_pkg::CFG_HEIGHT_ROWS, height_data);
      write_reg(hgr_pkg::CFG_WIDTH_BYTES, width_data);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Sender pause: all owed writes out, then room for a cell still in flight
  task automatic drain();
    while (predictor.pending() != 0) @(posedge clk_i);
    repeat (DrainSettle) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_width_data();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'd40;
      3:       return 8'd41;
      default: return {2'($urandom_range(3)), 6'($urandom_range(1, 3))};
    endcase
  endfunction

  function automatic logic [7:0] pick_height_data();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'd192;
      3:       return 8'd193;
      default: return 8'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [2:0] pick_color(int unsigned mode);
    case (mode)
      1:       return $urandom_range(1) ? hgr_pkg::COLOR_WHITE : hgr_pkg::COLOR_BLACK;
      2: begin
        case ($urandom_range(3))
          0:       return hgr_pkg::COLOR_BLUE;
          1:       return hgr_pkg::COLOR_ORANGE;
          2:       return hgr_pkg::COLOR_VIOLET;
          default: return hgr_pkg::COLOR_GREEN;
        endcase
      end
      default: return 3'($urandom_range(7));
    endcase
  endfunction

  // Stimulus
  initial begin
    logic [2:0]  directed_cells[$];
    int unsigned phase, n_cells, mode;
    directed_cells = '{
      // one image at the reset size: every palette color once, then code 6
      hgr_pkg::COLOR_BLACK, hgr_pkg::COLOR_VIOLET, hgr_pkg::COLOR_GREEN,
      hgr_pkg::COLOR_BLUE, hgr_pkg::COLOR_ORANGE, hgr_pkg::COLOR_WHITE,
      ColorSpare6,
      // two rows: white runs, palette bytes, the other undefined code
      ColorSpare7, hgr_pkg::COLOR_WHITE, hgr_pkg::COLOR_WHITE, hgr_pkg::COLOR_BLUE,
      hgr_pkg::COLOR_ORANGE, hgr_pkg::COLOR_VIOLET, hgr_pkg::COLOR_GREEN,
      hgr_pkg::COLOR_BLUE, hgr_pkg::COLOR_BLUE, hgr_pkg::COLOR_BLUE,
      hgr_pkg::COLOR_ORANGE, hgr_pkg::COLOR_ORANGE, hgr_pkg::COLOR_ORANGE,
      hgr_pkg::COLOR_BLACK
    };
    phase = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset size first, then a two-row image of one byte pair per row
    for (int i = 0; i < directed_cells.size(); i++) begin
      if (i == 7) begin
        push_i <= 1'b0;
        drain();
        configure(8'd1, 8'd2, 1'b1);
      end
      offer_cell(directed_cells[i]);
    end
    push_i <= 1'b0;
    drain();

    // Random phases, each under its own register setting
    while (cells_sent < CellTarget) begin
      phase++;
      steady = (phase == 2 || phase == 4);
      configure(pick_width_data(), pick_height_data(), $urandom_range(3) == 0);
      if (phase == 2) begin
        hold_request = 1'b1;
        n_cells = 60;
      end else if (phase == 4) begin
        n_cells = 150;
      end else if (predictor.at_image_start() && predictor.image_cells() <= 120
                   && $urandom_range(1)) begin
        n_cells = predictor.image_cells() * $urandom_range(1, 2);
      end else begin
        n_cells = $urandom_range(10, 90);
      end
      mode = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (n_cells) offer_cell(pick_color(mode));
      push_i <= 1'b0;
      drain();
    end

    if (predictor.pending() != 0)
      predictor.report($sformatf("%0d byte writes never arrived", predictor.pending()));
    $display("Covered %0d cells under %0d register writes in %0d random phases",
             cells_sent, reg_writes, phase);
    $display("Checked %0d byte writes, %0d images closed, %0d cycles with input stalled",
             predictor.writes_checked, predictor.images_closed, full_stalls);
    if (predictor.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: hgr_color_magnify_2x.f
+incdir+hw/rtl
hw/rtl/hgr_pkg.sv
hw/rtl/hgr_front.sv
hw/rtl/hgr_queue.sv
hw/rtl/hgr_back.sv
hw/rtl/hgr_color_magnify_2x.sv
hw/rtl/hgr_checker.sv
verif/hgr_color_magnify_2x_tb.sv
